// File: hdl/ptts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; the top level, controller, output register and testbench import it.
`default_nettype none

package ptts_pkg;

  // Table size and result cap per tick
  localparam int TASKS       = 8;
  localparam int MAX_RESULTS = 8;

  // Address, count and firing-count widths
  localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW = $clog2(TASKS + 1);
  localparam int KW = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int ID_W  = 8;
  localparam int CNT_W = 16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STAT_ADDED    = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_REMOVED  = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_CLEARED  = 3'd5,
    STAT_FIRED    = 3'd6,
    STAT_NONE     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RM_WR,
    S_FINAL
  } state_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] countdown;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result word handed from the controller to the output register
  typedef struct packed {
    logic            valid;
    status_t         status;
    logic [ID_W-1:0] id;
    logic            last;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler: table RAM, controller and
// output register. Depends on ptts_pkg, ptts_ram, ptts_ctrl and ptts_outreg.
`default_nettype none

// The task table (identifier, period, countdown per entry) lives in one
// synchronous RAM of TASKS entries; only the entry count is cleared by reset,
// so there is no clearing pass. An input word is taken when the controller is
// idle. Clear and an add to a full table go straight to the result; add and
// remove walk the table one entry per cycle until the identifier is found (a
// remove that hits then moves the last entry into the freed slot); a tick
// visits every entry with one read-modify-write per cycle while no fired word
// waits on out_stall. A tick gives one word per fired task in table order, up
// to MAX_RESULTS words (last set on the final one), or a single "none fired"
// word. The output register lets the next input word be taken while the
// final result still waits on out_stall.
module periodic_task_tick_scheduler import ptts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_mode,
  input  wire logic [ID_W-1:0]   in_task_id,
  input  wire logic [CNT_W-1:0]  in_period,
  input  wire logic [CNT_W-1:0]  in_first_delay,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_status,
  output logic [ID_W-1:0]        out_task_id_res,
  output logic                   out_last
);

  logic    ram_we;
  logic    ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t  ram_wdata;
  entry_t  ram_rdata;
  res_t    res;
  logic    res_ready;

  // Task table
  ptts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Table walker
  ptts_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_task_id     (in_task_id),
    .in_period      (in_period),
    .in_first_delay (in_first_delay),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .res            (res),
    .res_ready      (res_ready)
  );

  // Result word register
  ptts_outreg u_outreg (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (res),
    .res_ready       (res_ready),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_task_id_res (out_task_id_res),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// File: hdl/ptts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; width and depth come from parameters.
`default_nettype none

module ptts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, data held when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/ptts_outreg.sv
// Output register for result words: decouples the controller from out_stall.
// Depends on ptts_pkg for the result word type.
`default_nettype none

module ptts_outreg import ptts_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire res_t            res,
  output logic                 res_ready,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [ID_W-1:0]      out_task_id_res,
  output logic                 out_last
);

  logic            valid_r, valid_nxt;
  logic [2:0]      status_r;
  logic [ID_W-1:0] id_r;
  logic            last_r;
  logic            push;

  // Slot is free when empty or being drained this cycle
  assign res_ready = !valid_r || !out_stall;
  assign push      = res.valid && res_ready;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (push) begin
      valid_nxt = 1'b1;
    end
  end

  // Control bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      status_r <= res.status;
      id_r     <= res.id;
      last_r   <= res.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_task_id_res = id_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

// File: hdl/ptts_ctrl.sv
// Scheduler controller: sequencer that walks the task table in the RAM, one
// entry per cycle (a tick rewrites each entry, and can hold). Depends on ptts_pkg.
`default_nettype none

module ptts_ctrl import ptts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input word
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_mode,
  input  wire logic [ID_W-1:0]   in_task_id,
  input  wire logic [CNT_W-1:0]  in_period,
  input  wire logic [CNT_W-1:0]  in_first_delay,
  // table RAM
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output entry_t                 ram_wdata,
  output logic                   ram_re,
  output logic [AW-1:0]          ram_raddr,
  input  wire entry_t            ram_rdata,
  // result words
  output res_t                   res,
  input  wire logic              res_ready
);

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [CNT_W-1:0] per_r, per_nxt;
  logic [CNT_W-1:0] dly_r, dly_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    chk_idx_r, chk_idx_nxt;
  logic             chk_valid_r, chk_valid_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]  pend_id_r, pend_id_nxt;
  logic [KW-1:0]    fire_k_r, fire_k_nxt;
  status_t          fin_status_r, fin_status_nxt;
  logic [ID_W-1:0]  fin_id_r, fin_id_nxt;

  logic [CW-1:0]    idx_next;
  logic [CW-1:0]    last_idx;
  logic             hit;
  logic             fire;
  logic             report;
  logic             advance;

  assign in_stall = (state_r != S_IDLE);
  assign idx_next = chk_idx_r + 1'b1;
  assign last_idx = cnt_r - 1'b1;
  assign hit      = (ram_rdata.id == id_r);
  assign fire     = (ram_rdata.countdown == '0);
  assign report   = fire && (fire_k_r < KW'(MAX_RESULTS));

  // Next state, RAM access and result generation
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    per_nxt        = per_r;
    dly_nxt        = dly_r;
    cnt_nxt        = cnt_r;
    chk_idx_nxt    = chk_idx_r;
    chk_valid_nxt  = chk_valid_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    fire_k_nxt     = fire_k_r;
    fin_status_nxt = fin_status_r;
    fin_id_nxt     = fin_id_r;

    ram_we    = 1'b0;
    ram_waddr = chk_idx_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;

    res.valid  = 1'b0;
    res.status = fin_status_r;
    res.id     = fin_id_r;
    res.last   = 1'b1;

    advance = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = mode_t'(in_mode);
          id_nxt   = in_task_id;
          per_nxt  = in_period;
          dly_nxt  = in_first_delay;
          priority if (mode_t'(in_mode) == MODE_CLEAR) begin
            cnt_nxt        = '0;
            fin_status_nxt = STAT_CLEARED;
            fin_id_nxt     = '0;
            state_nxt      = S_FINAL;
          end else if (mode_t'(in_mode) == MODE_ADD && cnt_r == CW'(TASKS)) begin
            fin_status_nxt = STAT_FULL;
            fin_id_nxt     = in_task_id;
            state_nxt      = S_FINAL;
          end else begin
            // start the walk at entry 0
            ram_re         = 1'b1;
            ram_raddr      = '0;
            chk_idx_nxt    = '0;
            chk_valid_nxt  = (cnt_r != '0);
            pend_valid_nxt = 1'b0;
            fire_k_nxt     = '0;
            state_nxt      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (!chk_valid_r) begin
          // walked past the last entry
          state_nxt = S_FINAL;
          unique case (mode_r)
            MODE_ADD: begin
              ram_we              = 1'b1;
              ram_waddr           = cnt_r[AW-1:0];
              ram_wdata.id        = id_r;
              ram_wdata.period    = per_r;
              ram_wdata.countdown = dly_r;
              cnt_nxt             = cnt_r + 1'b1;
              fin_status_nxt      = STAT_ADDED;
              fin_id_nxt          = id_r;
            end
            MODE_REMOVE: begin
              fin_status_nxt = STAT_NOTFOUND;
              fin_id_nxt     = id_r;
            end
            MODE_TICK: begin
              fin_status_nxt = pend_valid_r ? STAT_FIRED : STAT_NONE;
              fin_id_nxt     = pend_valid_r ? pend_id_r : '0;
            end
            MODE_CLEAR: begin
              fin_status_nxt = STAT_CLEARED;
              fin_id_nxt     = '0;
            end
          endcase
        end else begin
          unique case (mode_r)
            MODE_ADD: begin
              if (hit) begin
                // update in place
                ram_we              = 1'b1;
                ram_wdata.id        = id_r;
                ram_wdata.period    = per_r;
                ram_wdata.countdown = dly_r;
                fin_status_nxt      = STAT_UPDATED;
                fin_id_nxt          = id_r;
                state_nxt           = S_FINAL;
              end else begin
                advance = 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (hit) begin
                // fetch the last entry to move into this slot
                ram_re    = 1'b1;
                ram_raddr = last_idx[AW-1:0];
                state_nxt = S_RM_WR;
              end else begin
                advance = 1'b1;
              end
            end
            MODE_TICK: begin
              // hold the walk while an earlier firing cannot be sent
              if (!(report && pend_valid_r && !res_ready)) begin
                ram_we = 1'b1;
                ram_wdata.countdown = fire ? (ram_rdata.period - 1'b1)
                                           : (ram_rdata.countdown - 1'b1);
                if (report) begin
                  if (pend_valid_r) begin
                    res.valid  = 1'b1;
                    res.status = STAT_FIRED;
                    res.id     = pend_id_r;
                    res.last   = 1'b0;
                  end
                  pend_valid_nxt = 1'b1;
                  pend_id_nxt    = ram_rdata.id;
                  fire_k_nxt     = fire_k_r + 1'b1;
                end
                advance = 1'b1;
              end
            end
            MODE_CLEAR: begin
              state_nxt = S_FINAL;
            end
          endcase
        end

        // step to the next entry, prefetching it
        if (advance) begin
          chk_idx_nxt   = idx_next;
          chk_valid_nxt = (idx_next < cnt_r);
          if (idx_next < cnt_r) begin
            ram_re    = 1'b1;
            ram_raddr = idx_next[AW-1:0];
          end
        end
      end

      S_RM_WR: begin
        // last entry is in the read register now
        ram_we         = 1'b1;
        ram_wdata      = ram_rdata;
        cnt_nxt        = last_idx;
        fin_status_nxt = STAT_REMOVED;
        fin_id_nxt     = id_r;
        state_nxt      = S_FINAL;
      end

      S_FINAL: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      chk_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      fire_k_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      chk_valid_r  <= chk_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      fire_k_r     <= fire_k_nxt;
    end
  end

  // Item payload and walk bookkeeping
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    id_r         <= id_nxt;
    per_r        <= per_nxt;
    dly_r        <= dly_nxt;
    chk_idx_r    <= chk_idx_nxt;
    pend_id_r    <= pend_id_nxt;
    fin_status_r <= fin_status_nxt;
    fin_id_r     <= fin_id_nxt;
  end

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for periodic_task_tick_scheduler: directed tests, then random
// table traffic with stalls on both sides. Depends on ptts_pkg and the block's RTL.

module testbench;
  import ptts_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 2 * TASKS + 8;

  // One expected result word
  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] id;
    logic            last;
  } sched_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode = MODE_ADD;
  logic [ID_W-1:0]   in_task_id = '0;
  logic [CNT_W-1:0]  in_period = '0;
  logic [CNT_W-1:0]  in_first_delay = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_status;
  logic [ID_W-1:0]   out_task_id_res;
  logic              out_last;

  // Shadow copy of the task table
  logic [ID_W-1:0]   tbl_ids [TASKS];
  logic [CNT_W-1:0]  tbl_periods [TASKS];
  logic [CNT_W-1:0]  tbl_countdowns [TASKS];
  int                tbl_count = 0;

  sched_result_t     expected_words[$];
  sched_result_t     want_word;
  int                error_count = 0;
  int                cycle_count = 0;
  int                hold_left = 0;
  bit                idle_on = 1'b1;

  periodic_task_tick_scheduler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_task_id      (in_task_id),
    .in_period       (in_period),
    .in_first_delay  (in_first_delay),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_task_id_res (out_task_id_res),
    .out_last        (out_last)
  );

  // Clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Receiver stall: long hold-off when requested, else random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (idle_on) begin
      out_stall = ($urandom_range(99) < 20);
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic void push_result(status_t st, logic [ID_W-1:0] id, logic last);
    sched_result_t w;
    w.status = st;
    w.id = id;
    w.last = last;
    expected_words.push_back(w);
  endfunction

  // Updates the shadow table for one accepted word and queues its results
  function automatic void predict_schedule(mode_t m, logic [ID_W-1:0] id,
                                           logic [CNT_W-1:0] per, logic [CNT_W-1:0] dly);
    int slot;
    int due;
    int fired;
    slot = -1;
    due = 0;
    fired = 0;
    case (m)
      MODE_ADD: begin
        if (tbl_count >= TASKS) begin
          push_result(STAT_FULL, id, 1'b1);
        end else begin
          for (int i = 0; i < tbl_count; i++)
            if (slot < 0 && tbl_ids[i] == id) slot = i;
          if (slot < 0) begin
            slot = tbl_count;
            tbl_count++;
            push_result(STAT_ADDED, id, 1'b1);
          end else begin
            push_result(STAT_UPDATED, id, 1'b1);
          end
          tbl_ids[slot] = id;
          tbl_periods[slot] = per;
          tbl_countdowns[slot] = dly;
        end
      end
      MODE_REMOVE: begin
        for (int i = 0; i < tbl_count; i++)
          if (slot < 0 && tbl_ids[i] == id) slot = i;
        if (slot < 0) begin
          push_result(STAT_NOTFOUND, id, 1'b1);
        end else begin
          // last entry moves into the freed slot
          tbl_ids[slot] = tbl_ids[tbl_count-1];
          tbl_periods[slot] = tbl_periods[tbl_count-1];
          tbl_countdowns[slot] = tbl_countdowns[tbl_count-1];
          tbl_count--;
          push_result(STAT_REMOVED, id, 1'b1);
        end
      end
      MODE_CLEAR: begin
        tbl_count = 0;
        push_result(STAT_CLEARED, '0, 1'b1);
      end
      default: begin
        // count due tasks first so the final reported firing carries last
        for (int i = 0; i < tbl_count; i++)
          if (tbl_countdowns[i] == '0) due++;
        if (due > MAX_RESULTS) due = MAX_RESULTS;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_countdowns[i] != '0) begin
            tbl_countdowns[i] = tbl_countdowns[i] - 1'b1;
          end else begin
            if (fired < MAX_RESULTS) begin
              push_result(STAT_FIRED, tbl_ids[i], fired == due - 1);
              fired++;
            end
            tbl_countdowns[i] = tbl_periods[i] - 1'b1;
          end
        end
        if (due == 0) push_result(STAT_NONE, '0, 1'b1);
      end
    endcase
  endfunction

  // Offers one word, waits for acceptance, returns at the next falling edge
  task automatic send_word(input mode_t m, input logic [ID_W-1:0] id,
                           input logic [CNT_W-1:0] per, input logic [CNT_W-1:0] dly);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = m;
    in_task_id = id;
    in_period = per;
    in_first_delay = dly;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_schedule(m, id, per, dly);
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: status %0d id %0d last %0d",
               out_status, out_task_id_res, out_last);
        error_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (out_status !== want_word.status) begin
          $error("status: expected %0d, got %0d", want_word.status, out_status);
          error_count++;
        end
        if (out_task_id_res !== want_word.id) begin
          $error("task_id_res: expected %0d, got %0d", want_word.id, out_task_id_res);
          error_count++;
        end
        if (out_last !== want_word.last) begin
          $error("last: expected %0d, got %0d", want_word.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Operations on an empty table
  task automatic test_empty_table();
    send_word(MODE_TICK, 8'd0, 16'd0, 16'd0);
    send_word(MODE_REMOVE, 8'd5, 16'd0, 16'd0);
    send_word(MODE_CLEAR, 8'd0, 16'd0, 16'd0);
  endtask

  // Append, update in place, period zero reload wrap
  task automatic test_add_update();
    send_word(MODE_ADD, 8'd0, 16'd0, 16'd0);
    send_word(MODE_TICK, 8'd0, 16'd0, 16'd0);
    send_word(MODE_TICK, 8'd0, 16'd0, 16'd0);
    send_word(MODE_ADD, 8'd255, 16'hFFFF, 16'hFFFF);
    send_word(MODE_ADD, 8'd0, 16'd3, 16'd1);
  endtask

  // Fill the table, then add both a known and a new id
  task automatic test_full_table();
    for (int i = 1; i <= TASKS - 2; i++)
      send_word(MODE_ADD, ID_W'(i), 16'd2, 16'd0);
    send_word(MODE_ADD, 8'd255, 16'd1, 16'd1);
    send_word(MODE_ADD, 8'd77, 16'd1, 16'd1);
  endtask

  // Several firings in one tick
  task automatic test_tick_firing();
    send_word(MODE_TICK, 8'd0, 16'd0, 16'd0);
    send_word(MODE_TICK, 8'd0, 16'd0, 16'd0);
  endtask

  // Remove from the middle, absent id, then clear
  task automatic test_remove();
    send_word(MODE_REMOVE, 8'd1, 16'd0, 16'd0);
    send_word(MODE_REMOVE, 8'd99, 16'd0, 16'd0);
    send_word(MODE_REMOVE, 8'd6, 16'd0, 16'd0);
    send_word(MODE_CLEAR, 8'd0, 16'd0, 16'd0);
    send_word(MODE_TICK, 8'd0, 16'd0, 16'd0);
  endtask

  // Receiver holds off while full-fire ticks keep coming
  task automatic test_backpressure();
    idle_on = 1'b0;
    send_word(MODE_CLEAR, 8'd0, 16'd0, 16'd0);
    for (int i = 0; i < TASKS; i++)
      send_word(MODE_ADD, ID_W'(10 + i), 16'd1, 16'd0);
    hold_left = 400;
    for (int i = 0; i < 24; i++)
      send_word(MODE_TICK, 8'd0, 16'd0, 16'd0);
    idle_on = 1'b1;
  endtask

  // Random traffic over a small id pool so updates, removes and firings hit often
  task automatic test_random(input int count);
    int sel;
    mode_t m;
    logic [ID_W-1:0] id;
    logic [CNT_W-1:0] per;
    logic [CNT_W-1:0] dly;
    for (int n = 0; n < count; n++) begin
      idle_on = !(n >= 150 && n < 230);
      sel = $urandom_range(99);
      if (sel < 32) m = MODE_ADD;
      else if (sel < 48) m = MODE_REMOVE;
      else if (sel < 51) m = MODE_CLEAR;
      else m = MODE_TICK;
      id = ($urandom_range(9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(11));
      per = ($urandom_range(9) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(4));
      dly = ($urandom_range(9) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(4));
      send_word(m, id, per, dly);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_table();
    test_add_update();
    test_full_table();
    test_tick_firing();
    test_remove();
    test_backpressure();
    test_random(395);

    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ptts_pkg.sv
hdl/ptts_ram.sv
hdl/ptts_outreg.sv
hdl/ptts_ctrl.sv
hdl/periodic_task_tick_scheduler.sv
verif/testbench.sv
